@@ src/tadc_pkg.sv @@
// Shared types, constants and resistance table for the thermistor converter.
`timescale 1ns / 1ps

package tadc_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int TEMP_W     = 11;
    localparam int DIVIDEND_W = 22;
    localparam int DIVISOR_W  = 15;
    localparam int STEP_W     = 5;
    localparam int VOLTS_W    = 9;
    localparam int RES_W      = 22;
    localparam int ROM_W      = 19;
    localparam int IDX_W      = 8;
    localparam int ROM_SIZE   = 140;
    localparam int COLD_DEG   = -40;

    localparam logic [DIVIDEND_W-1:0] VOLT_SCALE  = DIVIDEND_W'(300);
    localparam logic [DIVISOR_W-1:0]  ADC_FULL    = DIVISOR_W'(4095);
    localparam logic [DIVIDEND_W-1:0] RES_NUMER   = DIVIDEND_W'(3000000);
    localparam logic [RES_W-1:0]      SERIES_OHMS = RES_W'(10000);
    localparam logic signed [TEMP_W-1:0] COLD_TENTHS = TEMP_W'(COLD_DEG * 10);

    // Thermistor resistance in ohms, one entry per whole degree from -40 C up.
    localparam logic [ROM_W-1:0] RES_ROM [0:ROM_SIZE-1] = '{
        19'd431000, 19'd401700, 19'd374500, 19'd349400, 19'd326100,
        19'd304500, 19'd284500, 19'd265900, 19'd248600, 19'd232500,
        19'd217600, 19'd203800, 19'd190900, 19'd178900, 19'd167700,
        19'd157300, 19'd147600, 19'd138500, 19'd130100, 19'd122200,
        19'd114800, 19'd108000, 19'd101500, 19'd95530,  19'd89910,
        19'd84660,  19'd79740,  19'd75140,  19'd70830,  19'd66780,
        19'd63000,  19'd59450,  19'd56110,  19'd52990,  19'd50050,
        19'd47300,  19'd44710,  19'd42280,  19'd39990,  19'd37840,
        19'd35820,  19'd33910,  19'd32120,  19'd30430,  19'd28840,
        19'd27340,  19'd25920,  19'd24590,  19'd23330,  19'd22140,
        19'd21020,  19'd19970,  19'd18970,  19'd18020,  19'd17130,
        19'd16290,  19'd15490,  19'd14740,  19'd14030,  19'd13350,
        19'd12720,  19'd12110,  19'd11540,  19'd11000,  19'd10490,
        19'd10000,  19'd9539,   19'd9102,   19'd8688,   19'd8294,
        19'd7921,   19'd7566,   19'd7229,   19'd6909,   19'd6605,
        19'd6315,   19'd6040,   19'd5779,   19'd5530,   19'd5293,
        19'd5067,   19'd4852,   19'd4647,   19'd4452,   19'd4267,
        19'd4090,   19'd3921,   19'd3760,   19'd3606,   19'd3459,
        19'd3319,   19'd3186,   19'd3058,   19'd2937,   19'd2820,
        19'd2709,   19'd2603,   19'd2501,   19'd2404,   19'd2311,
        19'd2222,   19'd2137,   19'd2056,   19'd1978,   19'd1903,
        19'd1832,   19'd1764,   19'd1698,   19'd1636,   19'd1576,
        19'd1518,   19'd1463,   19'd1410,   19'd1359,   19'd1311,
        19'd1264,   19'd1219,   19'd1176,   19'd1135,   19'd1095,
        19'd1057,   19'd1020,   19'd985,    19'd951,    19'd918,
        19'd887,    19'd857,    19'd828,    19'd799,    19'd772,
        19'd746,    19'd721,    19'd697,    19'd674,    19'd652,
        19'd630,    19'd610,    19'd590,    19'd571,    19'd552
    };

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } div_rsp_t;

endpackage

@@ src/tadc_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module tadc_div
    import tadc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;

    logic [DIVISOR_W:0] shifted;
    logic [DIVISOR_W:0] diff;
    logic               fits;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    // A result is reported only at the end of a running division.
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    // A new division leaves the unit busy in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg && !done_reg)
        else $error("divider did not start");

    // The final remainder stays below the divisor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> rem_reg < dvs_reg)
        else $error("divider remainder out of range");

endmodule

@@ src/thermistor_adc_to_temperature.sv @@
// Top level: thermistor ADC sample to temperature in tenths of a degree.
`timescale 1ns / 1ps

// Usage
//   Input channel s_*: one 12-bit ADC word per handshake on s_valid/s_ready.
//   Result channel m_*: one word per input, m_temp_tenths (signed tenths of
//   a degree C, -400..990) with m_out_of_range set when the reading is
//   clamped at the cold or hot end of the table.
//   Each word runs through one shared serial divider up to three times
//   (volts = 300*sample/4095, ohms = 3000000/volts - 10000, and the
//   interpolation fraction), plus a table walk of one entry per cycle.
//   A zero-volt reading finishes after the first division and a reading
//   clamped in the table walk after the second. s_ready is high only
//   while the sequencer is idle, so one word is in flight at a time.
//   The result sits in an output register: the next input word is taken
//   while a finished result still waits. If the receiver stalls and a second
//   result is ready, the sequencer holds it until m_ready frees the register.
//   Reset (aresetn low, synchronous) returns the sequencer to idle and drops
//   any pending result.
module thermistor_adc_to_temperature
    import tadc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 140
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [SAMPLE_W-1:0]      s_adc_sample,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [TEMP_W-1:0] m_temp_tenths,
    output logic                     m_out_of_range
);

    // Searched depth; entries past the table act as the table's end.
    localparam int LAST_IDX =
        (TABLE_ENTRIES < ROM_SIZE ? TABLE_ENTRIES : ROM_SIZE) - 1;
    localparam logic [IDX_W-1:0] LAST_IDX_V = IDX_W'(LAST_IDX);
    localparam logic signed [TEMP_W-1:0] HOT_TENTHS =
        TEMP_W'(10 * (COLD_DEG + LAST_IDX));
    // Indices at or below this one interpolate from a negative whole degree.
    localparam logic [IDX_W-1:0] NEG_IDX_MAX = IDX_W'(-COLD_DEG);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_VOLTS,
        ST_DIV_RES,
        ST_SEARCH,
        ST_SETUP_FRAC,
        ST_DIV_FRAC,
        ST_OUT
    } state_t;

    state_t                    state_reg, state_next;
    div_req_t                  req_reg, req_next;
    div_rsp_t                  rsp;
    logic                      m_valid_reg, m_valid_next;
    logic signed [TEMP_W-1:0]  m_temp_reg, m_temp_next;
    logic                      m_oor_reg, m_oor_next;
    logic [RES_W-1:0]          res_reg, res_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [ROM_W-1:0]          prev_reg, prev_next;
    logic [ROM_W-1:0]          rlo_reg, rlo_next;
    logic signed [TEMP_W-1:0]  temp_reg, temp_next;
    logic                      oor_reg, oor_next;

    logic [ROM_W-1:0]          entry;
    logic [ROM_W-1:0]          span;
    logic [ROM_W-1:0]          offset;
    logic [ROM_W-1:0]          offset_x10;
    logic [VOLTS_W-1:0]        volts;
    logic signed [TEMP_W-1:0]  y0;
    logic signed [TEMP_W-1:0]  y0_tenths;
    logic [3:0]                frac;

    tadc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_reg),
        .rsp     (rsp)
    );

    assign entry      = RES_ROM[idx_reg];
    assign span       = prev_reg - rlo_reg;
    // Interpolation only runs with the resistance below the previous entry.
    assign offset     = prev_reg - res_reg[ROM_W-1:0];
    assign offset_x10 = ROM_W'({4'd0, offset[DIVISOR_W-1:0]} * ROM_W'(10));
    assign volts      = rsp.quotient[VOLTS_W-1:0];

    // Lower whole degree of the interval; division truncates toward zero,
    // so round the fraction up when that degree is below zero.
    assign y0        = TEMP_W'($signed({1'b0, idx_reg})) - TEMP_W'(1 - COLD_DEG);
    assign y0_tenths = TEMP_W'(y0 * TEMP_W'(10));
    assign frac      = rsp.quotient[3:0] +
                       4'((idx_reg <= NEG_IDX_MAX) && (rsp.remainder != '0));

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        req_next.start = 1'b0;
        m_valid_next = m_valid_reg;
        m_temp_next  = m_temp_reg;
        m_oor_next   = m_oor_reg;
        res_next     = res_reg;
        idx_next     = idx_reg;
        prev_next    = prev_reg;
        rlo_next     = rlo_reg;
        temp_next    = temp_reg;
        oor_next     = oor_reg;

        // Drop the result once the receiver takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next.start    = 1'b1;
                    req_next.dividend = {10'd0, s_adc_sample} * VOLT_SCALE;
                    req_next.divisor  = ADC_FULL;
                    state_next        = ST_DIV_VOLTS;
                end
            end
            ST_DIV_VOLTS: begin
                if (rsp.done) begin
                    if (volts == '0) begin
                        temp_next  = COLD_TENTHS;
                        oor_next   = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        req_next.start    = 1'b1;
                        req_next.dividend = RES_NUMER;
                        req_next.divisor  = DIVISOR_W'(volts);
                        state_next        = ST_DIV_RES;
                    end
                end
            end
            ST_DIV_RES: begin
                if (rsp.done) begin
                    res_next   = rsp.quotient[RES_W-1:0] - SERIES_OHMS;
                    idx_next   = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // Walk the descending table one entry per cycle.
                if (RES_W'(entry) <= res_reg) begin
                    if (idx_reg == '0) begin
                        temp_next  = COLD_TENTHS;
                        oor_next   = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        rlo_next   = entry;
                        state_next = ST_SETUP_FRAC;
                    end
                end else if (idx_reg == LAST_IDX_V) begin
                    temp_next  = HOT_TENTHS;
                    oor_next   = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    prev_next = entry;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            ST_SETUP_FRAC: begin
                req_next.start    = 1'b1;
                req_next.dividend = DIVIDEND_W'(offset_x10);
                req_next.divisor  = span[DIVISOR_W-1:0];
                state_next        = ST_DIV_FRAC;
            end
            ST_DIV_FRAC: begin
                if (rsp.done) begin
                    temp_next  = y0_tenths + TEMP_W'(frac);
                    oor_next   = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_temp_next  = temp_reg;
                    m_oor_next   = oor_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            req_reg.start <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            req_reg.start <= req_next.start;
            m_valid_reg   <= m_valid_next;
        end
        req_reg.dividend <= req_next.dividend;
        req_reg.divisor  <= req_next.divisor;
        m_temp_reg       <= m_temp_next;
        m_oor_reg        <= m_oor_next;
        res_reg          <= res_next;
        idx_reg          <= idx_next;
        prev_reg         <= prev_next;
        rlo_reg          <= rlo_next;
        temp_reg         <= temp_next;
        oor_reg          <= oor_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_temp_tenths  = m_temp_reg;
    assign m_out_of_range = m_oor_reg;

    // An accepted word keeps the input closed while it is converted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a conversion runs");

    // A clamped result sits exactly at one of the table limits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |->
            (m_temp_tenths == COLD_TENTHS) || (m_temp_tenths == HOT_TENTHS))
        else $error("clamped result off the table limits");

    // An interpolated result stays above the cold limit and no higher than the hot limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_of_range |->
            (m_temp_tenths > COLD_TENTHS) && (m_temp_tenths <= HOT_TENTHS))
        else $error("interpolated result out of span");

    // The divider answers only while the sequencer waits on it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> (state_reg == ST_DIV_VOLTS) || (state_reg == ST_DIV_RES) ||
            (state_reg == ST_DIV_FRAC))
        else $error("divider result with no division pending");

endmodule
